// ===== src/fcr_pkg.sv =====
// Shared types, constants and the byte-wide CRC-16/MODBUS update for the
// frame checker/router. No dependencies.
`default_nettype none
package fcr_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [15:0] SENDER_POS     = 16'd0;
  localparam logic [15:0] RECEIVER_POS   = 16'd1;
  localparam logic [15:0] PORT_POS       = 16'd2;
  localparam logic [15:0] IDENT_HIGH_POS = 16'd3;
  localparam logic [15:0] IDENT_LOW_POS  = 16'd4;
  localparam logic [15:0] REQUEST_POS    = 16'd5;

  localparam int CFG_IDX_W = 3;
  localparam int OUT_W     = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXPECTED_SENDER = 3'd0,
    REG_OWN_ADDRESS     = 3'd1,
    REG_CLIENT_ADDRESS  = 3'd2,
    REG_DEVICE_PORT     = 3'd3,
    REG_RTR_PORT        = 3'd4,
    REG_MIN_FRAME_LEN   = 3'd5,
    REG_MIN_DEV_LEN     = 3'd6,
    REG_UNUSED          = 3'd7
  } cfg_index_t;

  typedef enum logic [2:0] {
    V_DEVICE   = 3'd0,
    V_CLIENT   = 3'd1,
    V_RTR      = 3'd2,
    V_SHORT    = 3'd3,
    V_CRC      = 3'd4,
    V_SENDER   = 3'd5,
    V_PORT     = 3'd6,
    V_RECEIVER = 3'd7
  } verdict_t;

  typedef struct packed {
    logic [7:0] expected_sender;
    logic [7:0] own_address;
    logic [7:0] client_address;
    logic [7:0] device_port;
    logic [7:0] rtr_port;
    logic [7:0] min_frame_length;
    logic [7:0] min_device_frame_length;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [7:0]  port_number;
    logic [15:0] device_ident;
    logic [7:0]  request_code;
  } result_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== src/fcr_cfg.sv =====
// Configuration register file of the frame checker/router.
// Depends on fcr_pkg (cfg_t, register indexes).
`default_nettype none
module fcr_cfg (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            wr_en,
  input  wire [fcr_pkg::CFG_IDX_W-1:0]   wr_index,
  input  wire [7:0]                      wr_data,
  output fcr_pkg::cfg_t                  cfg
);

  fcr_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_sender         <= 8'd0;
      cfg_r.own_address             <= 8'd1;
      cfg_r.client_address          <= 8'd2;
      cfg_r.device_port             <= 8'd0;
      cfg_r.rtr_port                <= 8'd1;
      cfg_r.min_frame_length        <= 8'd5;
      cfg_r.min_device_frame_length <= 8'd8;
    end else if (wr_en) begin
      unique case (fcr_pkg::cfg_index_t'(wr_index))
        fcr_pkg::REG_EXPECTED_SENDER: cfg_r.expected_sender         <= wr_data;
        fcr_pkg::REG_OWN_ADDRESS:     cfg_r.own_address             <= wr_data;
        fcr_pkg::REG_CLIENT_ADDRESS:  cfg_r.client_address          <= wr_data;
        fcr_pkg::REG_DEVICE_PORT:     cfg_r.device_port             <= wr_data;
        fcr_pkg::REG_RTR_PORT:        cfg_r.rtr_port                <= wr_data;
        fcr_pkg::REG_MIN_FRAME_LEN:   cfg_r.min_frame_length        <= wr_data;
        fcr_pkg::REG_MIN_DEV_LEN:     cfg_r.min_device_frame_length <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== src/fcr_in_reg.sv =====
// Input register stage: holds one byte request and releases it when the
// frame stage can take it. Depends on fcr_pkg (in_item_t).
`default_nettype none
module fcr_in_reg (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire  [7:0]        in_data,
  input  wire               in_last,
  input  wire               out_slot_free,
  output fcr_pkg::in_item_t item,
  output logic              advance
);

  logic       valid_r, valid_nxt;
  logic       last_r;
  logic [7:0] data_r;

  // a non-last byte never produces a result, so it never waits on the output
  assign advance   = valid_r && (!last_r || out_slot_free);
  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= in_data;
      last_r <= in_last;
    end
  end

  assign item.valid = valid_r;
  assign item.last  = last_r;
  assign item.data  = data_r;

endmodule
`default_nettype wire

// ===== src/fcr_frame.sv =====
// Frame state (running CRC, saturating count, header captures) and the
// end-of-frame verdict logic. Depends on fcr_pkg (crc_feed, types).
`default_nettype none
module fcr_frame (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                step,
  input  fcr_pkg::in_item_t  item,
  input  fcr_pkg::cfg_t      cfg,
  output fcr_pkg::result_t   result
);

  logic [15:0] crc_r, crc_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  sender_r, sender_nxt;
  logic [7:0]  receiver_r, receiver_nxt;
  logic [7:0]  port_r, port_nxt;
  logic [7:0]  id_hi_r, id_hi_nxt;
  logic [7:0]  id_lo_r, id_lo_nxt;
  logic [7:0]  req_r, req_nxt;

  logic        crc_bad;
  logic        short_frame;
  logic        short_device;

  assign crc_nxt      = fcr_pkg::crc_feed(crc_r, item.data);
  assign count_nxt    = (count_r == 16'hFFFF) ? count_r : count_r + 16'd1;
  assign sender_nxt   = (count_r == fcr_pkg::SENDER_POS)     ? item.data : sender_r;
  assign receiver_nxt = (count_r == fcr_pkg::RECEIVER_POS)   ? item.data : receiver_r;
  assign port_nxt     = (count_r == fcr_pkg::PORT_POS)       ? item.data : port_r;
  assign id_hi_nxt    = (count_r == fcr_pkg::IDENT_HIGH_POS) ? item.data : id_hi_r;
  assign id_lo_nxt    = (count_r == fcr_pkg::IDENT_LOW_POS)  ? item.data : id_lo_r;
  assign req_nxt      = (count_r == fcr_pkg::REQUEST_POS)    ? item.data : req_r;

  assign short_frame  = count_nxt < {8'd0, cfg.min_frame_length};
  assign short_device = count_nxt < {8'd0, cfg.min_device_frame_length};
  assign crc_bad      = (count_nxt < 16'd2) || (crc_nxt != 16'd0);

  always_comb begin
    result.port_number  = port_nxt;
    result.device_ident = 16'd0;
    result.request_code = 8'd0;
    priority if (short_frame) begin
      result.verdict = fcr_pkg::V_SHORT;
    end else if (crc_bad) begin
      result.verdict = fcr_pkg::V_CRC;
    end else if (sender_nxt != cfg.expected_sender) begin
      result.verdict = fcr_pkg::V_SENDER;
    end else if (receiver_nxt == cfg.own_address) begin
      priority if (port_nxt == cfg.device_port) begin
        if (short_device) begin
          result.verdict = fcr_pkg::V_SHORT;
        end else begin
          result.verdict      = fcr_pkg::V_DEVICE;
          result.device_ident = {id_hi_nxt, id_lo_nxt};
          result.request_code = req_nxt;
        end
      end else if (port_nxt == cfg.rtr_port) begin
        result.verdict = fcr_pkg::V_RTR;
      end else begin
        result.verdict = fcr_pkg::V_PORT;
      end
    end else if (receiver_nxt == cfg.client_address) begin
      result.verdict = fcr_pkg::V_CLIENT;
    end else begin
      result.verdict = fcr_pkg::V_RECEIVER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last)) begin
      crc_r      <= fcr_pkg::CRC_INIT;
      count_r    <= 16'd0;
      sender_r   <= 8'd0;
      receiver_r <= 8'd0;
      port_r     <= 8'd0;
      id_hi_r    <= 8'd0;
      id_lo_r    <= 8'd0;
      req_r      <= 8'd0;
    end else if (step) begin
      crc_r      <= crc_nxt;
      count_r    <= count_nxt;
      sender_r   <= sender_nxt;
      receiver_r <= receiver_nxt;
      port_r     <= port_nxt;
      id_hi_r    <= id_hi_nxt;
      id_lo_r    <= id_lo_nxt;
      req_r      <= req_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/crc16_frame_checker_router.sv =====
// A byte accepted on in_* is held in the input stage; when a last byte advances,
// its verdict is loaded into the result stage and shown on out_* from then on.
// Throughput: one byte per cycle; a waiting verdict stalls only a last byte.
// Reset (rst_n low, synchronous): config returns to defaults, frame state
// clears (CRC 0xFFFF, count 0), both stages empty.
`default_nettype none
module crc16_frame_checker_router (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire  [7:0]                        in_tdata,   // [7:0] data_byte
  input  wire                               in_tlast,   // last_byte
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // [2:0] verdict, [10:3] port_number, [26:11] device_ident,
  // [34:27] request_code, [39:35] zero
  output logic [fcr_pkg::OUT_W-1:0]         out_tdata,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [fcr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [7:0]                        cfg_data
);

  fcr_pkg::cfg_t     cfg;
  fcr_pkg::in_item_t item;
  fcr_pkg::result_t  result;
  logic              advance;
  logic              out_slot_free;
  logic              out_valid_r, out_valid_nxt;
  logic [fcr_pkg::OUT_W-1:0] out_data_r;

  assign cfg_ready = 1'b1;

  fcr_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  fcr_in_reg u_in_reg (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_data       (in_tdata),
    .in_last       (in_tlast),
    .out_slot_free (out_slot_free),
    .item          (item),
    .advance       (advance)
  );

  fcr_frame u_frame (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  assign out_slot_free = !out_valid_r || out_tready;
  assign out_valid_nxt = (advance && item.last) || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.last) begin
      out_data_r <= {5'd0, result.request_code, result.device_ident,
                     result.port_number, result.verdict};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ===== src/fcr_checker.sv =====
// Port-level checker for the frame checker/router, bound to the top level.
// Depends on fcr_pkg (verdict codes) and crc16_frame_checker_router.
`default_nettype none
module fcr_checker (
  input wire                           clk,
  input wire                           rst_n,
  input wire                           in_tvalid,
  input wire                           in_tready,
  input wire                           out_tvalid,
  input wire                           out_tready,
  input wire [fcr_pkg::OUT_W-1:0]      out_tdata
);

  // a stalled verdict holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // ident and request are only reported with a device verdict
  a_dev_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != fcr_pkg::V_DEVICE |-> out_tdata[34:11] == 24'd0)
    else $error("ident/request set on non-device verdict");

  // pad bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:35] == 5'd0)
    else $error("pad bits of result nonzero");

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // the input side is never blocked by a free output slot
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !$past(in_tvalid) |-> in_tready)
    else $error("input stalled with empty pipeline");

endmodule

bind crc16_frame_checker_router fcr_checker u_fcr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
